// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, included by adat_merge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge except while reset is held.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/adat_pkg.sv =====
// ----------------------------------------------------------------------------
// ADAT frame encoder package
// Payload types, frame constants and the frame assembly function.
// ----------------------------------------------------------------------------
package adat_pkg;

    localparam int FRAME_WORDS = 8;
    localparam int WORD_W      = 32;
    localparam int NUM_CH      = 8;
    localparam int FRAME_W     = FRAME_WORDS * WORD_W;

    // Header: one, ten zeros, one, four user bits at zero.
    localparam logic [15:0] SYNC_HEADER = 16'h8010;

    typedef struct packed {
        logic [23:0] sample_ch0;
        logic [23:0] sample_ch1;
        logic [23:0] sample_ch2;
        logic [23:0] sample_ch3;
        logic [23:0] sample_ch4;
        logic [23:0] sample_ch5;
        logic [23:0] sample_ch6;
        logic [23:0] sample_ch7;
    } t_in_item;

    typedef struct packed {
        logic [31:0] line_word;
        logic        frame_end;
    } t_out_item;

    // Control handed from the lane stage to the merge stage.
    typedef struct packed {
        logic                   valid;
        logic [FRAME_WORDS-1:0] parity;
    } t_handoff;

    typedef logic [FRAME_WORDS-1:0][WORD_W-1:0] t_word_array;

    // Byte stuffing: [1][high nibble][1][low nibble].
    function automatic logic [9:0] stuff_byte(input logic [7:0] b);
        stuff_byte = {1'b1, b[7:4], 1'b1, b[3:0]};
    endfunction

    // Raw frame before line coding; bit FRAME_W-1 goes out first.
    function automatic logic [FRAME_W-1:0] build_frame(input t_in_item item);
        logic [NUM_CH-1:0][23:0] ch;
        logic [NUM_CH-1:0][29:0] tok;
        ch = {item.sample_ch0, item.sample_ch1, item.sample_ch2, item.sample_ch3,
              item.sample_ch4, item.sample_ch5, item.sample_ch6, item.sample_ch7};
        for (int i = 0; i < NUM_CH; i++) begin
            tok[i] = {stuff_byte(ch[i][23:16]), stuff_byte(ch[i][15:8]),
                      stuff_byte(ch[i][7:0])};
        end
        build_frame = {SYNC_HEADER, tok};
    endfunction

endpackage

// ===== hw/rtl/adat_lane.sv =====
// ----------------------------------------------------------------------------
// ADAT NRZI lane
// Codes one 32-bit raw word as if the line started low, and reports the
// word's parity so the merge stage can fix the starting level afterwards.
// ----------------------------------------------------------------------------
module adat_lane (
    input  logic [adat_pkg::WORD_W-1:0] i_raw,
    output logic [adat_pkg::WORD_W-1:0] o_level,
    output logic                        o_parity
);

    localparam int W      = adat_pkg::WORD_W;
    localparam int LEVELS = $clog2(W);

    // Prefix XOR from the top bit down, built as a log-depth scan.
    logic [LEVELS:0][W-1:0] scan;

    assign scan[0] = i_raw;

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        for (genvar b = 0; b < W; b++) begin : g_bit
            if (b + (1 << l) < W) begin : g_comb
                assign scan[l+1][b] = scan[l][b] ^ scan[l][b + (1 << l)];
            end else begin : g_pass
                assign scan[l+1][b] = scan[l][b];
            end
        end
    end

    assign o_level  = scan[LEVELS];
    assign o_parity = scan[LEVELS][0];

endmodule

// ===== hw/rtl/adat_merge.sv =====
// ----------------------------------------------------------------------------
// ADAT lane merge and word output
// Applies the running line level to the lane results, holds the coded
// frame and sends it out one 32-bit word per transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adat_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  adat_pkg::t_handoff   i_hand,
    input  adat_pkg::t_word_array i_local,
    output logic                 o_take,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output adat_pkg::t_out_item  o_out_data
);

    localparam int N     = adat_pkg::FRAME_WORDS;
    localparam int CNT_W = $clog2(N);

    logic                  r_b_valid, n_b_valid;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_level, n_level;
    adat_pkg::t_word_array r_words, n_words;

    logic [N:0]            carry;
    logic                  last_word;
    logic                  out_xfer;

    assign last_word = (r_cnt == CNT_W'(N - 1));
    assign out_xfer  = r_b_valid && i_out_ready;

    // A new frame moves in when the buffer is empty or its last word leaves.
    assign o_take = i_hand.valid && (!r_b_valid || (out_xfer && last_word));

    // Level entering each word: stored level plus parity of earlier words.
    always_comb begin
        carry[0] = r_level;
        for (int k = 0; k < N; k++) begin
            carry[k+1] = carry[k] ^ i_hand.parity[k];
        end
    end

    // Buffer control and word shifting.
    always_comb begin
        n_b_valid = r_b_valid;
        n_cnt     = r_cnt;
        n_level   = r_level;
        n_words   = r_words;
        if (o_take) begin
            n_b_valid = 1'b1;
            n_cnt     = '0;
            n_level   = carry[N];
            for (int k = 0; k < N; k++) begin
                n_words[k] = i_local[k] ^ {adat_pkg::WORD_W{carry[k]}};
            end
        end else if (out_xfer) begin
            n_cnt = r_cnt + 1'b1;
            for (int k = 0; k < N - 1; k++) begin
                n_words[k] = r_words[k+1];
            end
            if (last_word) begin
                n_b_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_cnt     <= '0;
            r_level   <= 1'b0;
        end else begin
            r_b_valid <= n_b_valid;
            r_cnt     <= n_cnt;
            r_level   <= n_level;
        end
        r_words <= n_words;
    end

    assign o_out_valid          = r_b_valid;
    assign o_out_data.line_word = r_words[0];
    assign o_out_data.frame_end = last_word;

    // The stored level advances by the parity of the whole frame.
    `ASSERT_RST(a_level_update, i_clk, i_rst_n,
        o_take |=> (r_level == ($past(r_level) ^ (^$past(i_hand.parity)))),
        "line level not advanced by frame parity")
    // A loaded frame starts at its first word and is shown at once.
    `ASSERT_RST(a_load_start, i_clk, i_rst_n,
        o_take |=> (o_out_valid && (r_cnt == '0)),
        "loaded frame does not start at word zero")
    // With nothing waiting, the buffer empties after the final word.
    `ASSERT_RST(a_drain, i_clk, i_rst_n,
        (out_xfer && last_word && !i_hand.valid) |=> !o_out_valid,
        "output still valid after the final word")
    // Reset empties the output.
    `ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !o_out_valid,
        "output valid right after reset")

endmodule

// ===== hw/rtl/adat_frame_nrzi_encoder_core.sv =====
// ----------------------------------------------------------------------------
// ADAT frame NRZI encoder core
// Builds and NRZI codes one 256-bit ADAT frame per sample frame.
// ----------------------------------------------------------------------------
// Each accepted sample frame (eight 24-bit channels) becomes eight 32-bit
// words of NRZI line levels, first transmitted bit in bit 31, with frame_end
// set on the eighth word. Output runs at one word per cycle while i_out_ready
// is high, a rate set by the single 32-bit output word. Eight lanes code the
// frame's words in parallel in the cycle of the input transfer and a register
// holds their results; the merge stage then applies the running line level
// and loads the output buffer as the previous frame's last word leaves, so
// frames stream without gaps. When the block is empty, the first word passes
// through the lane result register and then the output buffer. The line
// level starts low after reset.
module adat_frame_nrzi_encoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  adat_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output adat_pkg::t_out_item o_out_data
);

    localparam int N = adat_pkg::FRAME_WORDS;
    localparam int W = adat_pkg::WORD_W;

    logic [adat_pkg::FRAME_W-1:0] raw;
    adat_pkg::t_word_array        lane_level;
    logic [N-1:0]                 lane_par;

    logic                  r_a_valid, n_a_valid;
    adat_pkg::t_word_array r_a_local;
    logic [N-1:0]          r_a_par;
    adat_pkg::t_handoff    hand;
    logic                  take;
    logic                  in_xfer;

    // Frame assembly: header plus stuffed bytes.
    assign raw = adat_pkg::build_frame(i_in_data);

    // One lane per word of the frame.
    for (genvar k = 0; k < N; k++) begin : g_lane
        adat_lane u_lane (
            .i_raw    (raw[adat_pkg::FRAME_W - 1 - k*W -: W]),
            .o_level  (lane_level[k]),
            .o_parity (lane_par[k])
        );
    end

    // Lane result register.
    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_a_valid || take;

    always_comb begin
        n_a_valid = r_a_valid;
        if (in_xfer) begin
            n_a_valid = 1'b1;
        end else if (take) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
        end
        if (in_xfer) begin
            r_a_local <= lane_level;
            r_a_par   <= lane_par;
        end
    end

    assign hand.valid  = r_a_valid;
    assign hand.parity = r_a_par;

    // Level merge and word output.
    adat_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hand      (hand),
        .i_local     (r_a_local),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
